@@ rtl/tvfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tvfd_pkg;

  // result kinds
  localparam logic [2:0] KIND_SCALAR = 3'd0;
  localparam logic [2:0] KIND_ROWSEP = 3'd1;
  localparam logic [2:0] KIND_PBYTE  = 3'd2;
  localparam logic [2:0] KIND_EMPTY  = 3'd3;
  localparam logic [2:0] KIND_ABORT  = 3'd4;

  // field type codes
  localparam logic [3:0] FT_INT32  = 4'd0;
  localparam logic [3:0] FT_UINT32 = 4'd1;
  localparam logic [3:0] FT_INT64  = 4'd2;
  localparam logic [3:0] FT_UINT64 = 4'd3;
  localparam logic [3:0] FT_DOUBLE = 4'd4;
  localparam logic [3:0] FT_BOOL   = 4'd5;
  localparam logic [3:0] FT_ROWSEP = 4'd6;
  localparam logic [3:0] FT_STRING = 4'd7;
  localparam logic [3:0] FT_BYTES  = 4'd8;

  localparam logic [7:0] SEVEN_MASK = 8'h7F;
  localparam logic [6:0] SEVEN      = 7'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  field_index;
    logic [3:0]  field_type;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t rec;
  } qwr_t;

endpackage

`default_nettype wire

@@ rtl/tvfd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface tvfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tvfd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  field_index;
  logic [3:0]  field_type;
  logic [63:0] value;
  logic [7:0]  payload_byte;
  logic        last_of_run;

  modport source (output valid, output kind, output field_index, output field_type,
                  output value, output payload_byte, output last_of_run, input ready);
  modport sink (input valid, input kind, input field_index, input field_type,
                input value, input payload_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/tvfd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tvfd_front #(
  parameter int LEN_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  tvfd_byte_if.sink       in_ch,
  input  wire logic       q_full,
  output tvfd_pkg::qwr_t  wr
);
  import tvfd_pkg::*;

  localparam logic [2:0] PH_TAG_IDX  = 3'd0;
  localparam logic [2:0] PH_TAG_TYPE = 3'd1;
  localparam logic [2:0] PH_VARINT   = 3'd2;
  localparam logic [2:0] PH_FIXED    = 3'd3;
  localparam logic [2:0] PH_LEN      = 3'd4;
  localparam logic [2:0] PH_PAYLOAD  = 3'd5;
  localparam logic [2:0] PH_DISCARD  = 3'd6;

  logic [2:0]          phase, phase_next;
  logic [7:0]          fidx, fidx_next;
  logic [3:0]          ftype, ftype_next;
  logic [63:0]         acc, acc_next;
  logic [6:0]          shift_count, shift_count_next;
  logic [2:0]          fixed_cnt, fixed_cnt_next;
  logic [LEN_BITS-1:0] rem, rem_next;

  logic                accept;
  logic                emit;
  result_t             rec;
  logic [7:0]          b;
  logic                eob;
  logic [63:0]         g_acc;
  logic [6:0]          g_shift;
  logic [63:0]         f_acc;
  logic [LEN_BITS-1:0] rem_dec;
  logic                too_long;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;
  assign eob         = in_ch.end_of_buffer;

  // seven payload bits of a varint byte; bits beyond 63 fall off
  assign g_acc   = shift_count[6] ? acc
                 : acc | ({56'd0, b & SEVEN_MASK} << shift_count[5:0]);
  assign g_shift = (shift_count < 7'd70) ? shift_count + SEVEN : shift_count;
  assign f_acc   = acc | ({56'd0, b} << {fixed_cnt, 3'b000});
  assign rem_dec = (rem != '0) ? rem - 1'b1 : rem;
  assign too_long = |(g_acc >> LEN_BITS);

  always_comb begin
    phase_next       = phase;
    fidx_next        = fidx;
    ftype_next       = ftype;
    acc_next         = acc;
    shift_count_next = shift_count;
    fixed_cnt_next   = fixed_cnt;
    rem_next         = rem;
    emit             = 1'b0;
    rec              = '0;

    case (phase)
      PH_TAG_IDX: begin
        fidx_next  = b;
        phase_next = PH_TAG_TYPE;
      end
      PH_TAG_TYPE: begin
        phase_next = PH_TAG_IDX;
        if (b <= {4'd0, FT_BYTES}) begin
          ftype_next       = b[3:0];
          acc_next         = '0;
          shift_count_next = '0;
          fixed_cnt_next   = '0;
          case (b[3:0])
            FT_ROWSEP: begin
              emit     = 1'b1;
              rec.kind = KIND_ROWSEP;
            end
            FT_DOUBLE: begin
              if (eob) emit = 1'b1;
              else phase_next = PH_FIXED;
            end
            FT_STRING, FT_BYTES: begin
              if (eob) begin
                emit            = 1'b1;
                rec.kind        = KIND_EMPTY;
                rec.last_of_run = 1'b1;
              end else begin
                phase_next = PH_LEN;
              end
            end
            default: begin
              if (eob) emit = 1'b1;
              else phase_next = PH_VARINT;
            end
          endcase
        end
      end
      PH_VARINT: begin
        if (!b[7] || eob) begin
          emit             = 1'b1;
          rec.value        = g_acc;
          acc_next         = '0;
          shift_count_next = '0;
          fixed_cnt_next   = '0;
          phase_next       = PH_TAG_IDX;
        end else begin
          acc_next         = g_acc;
          shift_count_next = g_shift;
        end
      end
      PH_FIXED: begin
        fixed_cnt_next = fixed_cnt + 1'b1;
        acc_next       = f_acc;
        if (fixed_cnt == 3'd7) begin
          emit           = 1'b1;
          rec.value      = f_acc;
          acc_next       = '0;
          fixed_cnt_next = '0;
          phase_next     = PH_TAG_IDX;
        end else if (eob) begin
          // short double reports zero
          emit           = 1'b1;
          acc_next       = '0;
          fixed_cnt_next = '0;
          phase_next     = PH_TAG_IDX;
        end
      end
      PH_LEN: begin
        if (!b[7] || eob) begin
          acc_next         = '0;
          shift_count_next = '0;
          fixed_cnt_next   = '0;
          phase_next       = PH_TAG_IDX;
          if (g_acc == '0) begin
            emit            = 1'b1;
            rec.kind        = KIND_EMPTY;
            rec.last_of_run = 1'b1;
          end else if (too_long || eob) begin
            // oversized or cut-off length: abort; an oversized one drops bytes until the buffer ends
            emit            = 1'b1;
            rec.kind        = KIND_ABORT;
            rec.last_of_run = 1'b1;
            if (!eob) phase_next = PH_DISCARD;
          end else begin
            rem_next   = g_acc[LEN_BITS-1:0];
            phase_next = PH_PAYLOAD;
          end
        end else begin
          acc_next         = g_acc;
          shift_count_next = g_shift;
        end
      end
      PH_PAYLOAD: begin
        emit             = 1'b1;
        rec.payload_byte = b;
        rem_next         = rem_dec;
        if (rem_dec == '0) begin
          rec.kind        = KIND_PBYTE;
          rec.last_of_run = 1'b1;
          phase_next      = PH_TAG_IDX;
        end else if (eob) begin
          rec.kind        = KIND_ABORT;
          rec.last_of_run = 1'b1;
          rem_next        = '0;
          phase_next      = PH_TAG_IDX;
        end else begin
          rec.kind = KIND_PBYTE;
        end
      end
      PH_DISCARD: begin
        phase_next = PH_DISCARD;
      end
      default: begin
        phase_next = PH_TAG_IDX;
      end
    endcase

    // end of buffer always restarts the parse
    if (eob) begin
      phase_next       = PH_TAG_IDX;
      rem_next         = '0;
      acc_next         = '0;
      shift_count_next = '0;
      fixed_cnt_next   = '0;
    end

    rec.field_index = fidx;
    rec.field_type  = ftype_next;
  end

  assign wr.push = accept && emit;
  assign wr.rec  = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TAG_IDX;
      fidx        <= '0;
      ftype       <= '0;
      acc         <= '0;
      shift_count <= '0;
      fixed_cnt   <= '0;
      rem         <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      fidx        <= fidx_next;
      ftype       <= ftype_next;
      acc         <= acc_next;
      shift_count <= shift_count_next;
      fixed_cnt   <= fixed_cnt_next;
      rem         <= rem_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tvfd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tvfd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tvfd_pkg::qwr_t wr,
  output logic               full,
  output logic               q_valid,
  output tvfd_pkg::result_t  q_rec,
  input  wire logic          pop
);
  import tvfd_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_rec   = entries[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (wr.push) entries[wr_ptr] <= wr.rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr.push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({wr.push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/tvfd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tvfd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire tvfd_pkg::result_t q_rec,
  output logic                   pop,
  tvfd_result_if.source          out_ch
);
  import tvfd_pkg::*;

  result_t     out_rec;
  result_t     fin_rec;
  logic        out_valid;
  logic        load;
  logic [63:0] fin;
  logic [63:0] a;
  logic [31:0] z32;

  assign a   = q_rec.value;
  assign z32 = (a[31:0] >> 1) ^ {32{a[0]}};

  // zigzag for signed types, cut for 32-bit types, collapse for bool
  always_comb begin
    case (q_rec.field_type)
      FT_INT32:  fin = {{32{z32[31]}}, z32};
      FT_UINT32: fin = {32'd0, a[31:0]};
      FT_INT64:  fin = (a >> 1) ^ {64{a[0]}};
      FT_BOOL:   fin = {63'd0, |a};
      default:   fin = a;
    endcase
    fin_rec       = q_rec;
    fin_rec.value = fin;
  end

  assign load = !out_valid || out_ch.ready;
  assign pop  = load && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec <= fin_rec;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_rec.kind;
  assign out_ch.field_index  = out_rec.field_index;
  assign out_ch.field_type   = out_rec.field_type;
  assign out_ch.value        = out_rec.value;
  assign out_ch.payload_byte = out_rec.payload_byte;
  assign out_ch.last_of_run  = out_rec.last_of_run;

endmodule

`default_nettype wire

@@ rtl/tagged_varint_field_decoder.sv @@
// Path: a result passes through the two-entry result queue and then the output register to out_ch.
// Throughput: one byte per cycle; the parser takes a byte whenever the two-entry
// result queue has room, so only a stalled output slows the input side.
// Reset: synchronous rst returns the parser to the tag index byte and empties the
// queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module tagged_varint_field_decoder #(
  parameter int LEN_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tvfd_byte_if.sink     in_ch,
  tvfd_result_if.source out_ch
);
  import tvfd_pkg::*;

  qwr_t    wr;
  logic    q_full;
  logic    q_valid;
  result_t q_rec;
  logic    pop;

  tvfd_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .wr     (wr)
  );

  tvfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .full    (q_full),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .pop     (pop)
  );

  tvfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ rtl/tvfd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tvfd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  kind,
  input wire logic [3:0]  field_type,
  input wire logic [63:0] value,
  input wire logic        last_of_run
);
  import tvfd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(kind))
    else $error("stalled transaction changed");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_SCALAR |-> value == 64'd0)
    else $error("nonzero value on a non-scalar transaction");

  a_last_scalar: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_SCALAR || kind == KIND_ROWSEP) |-> !last_of_run)
    else $error("last_of_run set on scalar or row separator");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EMPTY || kind == KIND_ABORT) |-> last_of_run)
    else $error("last_of_run missing on empty or aborted payload");

  a_rowsep_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ROWSEP |-> field_type == FT_ROWSEP)
    else $error("row separator with wrong type");

endmodule

bind tagged_varint_field_decoder tvfd_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .field_type  (out_ch.field_type),
  .value       (out_ch.value),
  .last_of_run (out_ch.last_of_run)
);

`default_nettype wire
